// ===== design/wsa_pkg.sv =====
// Package for the worker select arbiter.
// Holds field widths, register indexes and policy codes; no dependencies.
package wsa_pkg;

  // Width of the per-worker masks and of the worker index field.
  localparam int MASK_BITS     = 16;
  localparam int IDX_W         = 4;
  localparam int COUNT_W       = 5;

  // Default number of workers the block is built for.
  localparam int DEF_MAX_WORKERS = 16;

  // Stream payload widths.
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 8;

  // Configuration port.
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  // Register indexes, taken from bit 2 of the byte address.
  localparam logic REG_WORKER_COUNT = 1'b0;
  localparam logic REG_POLICY_MODE  = 1'b1;

  // Selection policies.
  localparam logic MODE_ROUND_ROBIN = 1'b0;
  localparam logic MODE_RANDOM      = 1'b1;

endpackage

// ===== design/worker_select_arbiter.sv =====
// Worker select arbiter top level: one sequencer over a shared
// compare/subtract unit. Depends on wsa_pkg.
//
// Usage:
//   A request enters on the in_ stream (requester index, long-running mask,
//   non-empty mask, random value) and one result leaves on the out_ stream:
//   the selected worker in out_tdata and the found flag in out_tuser.
//   Round-robin mode (policy_mode 0) starts at an internal pointer and takes
//   the first worker that is not long-running; the pointer then moves past
//   the grant. Random mode (policy_mode 1) starts at random_value modulo the
//   worker count, skips the requester and takes the first worker that is not
//   long-running and has queued work.
//   Sequencing: the start index is first brought below the worker count by
//   repeated subtract steps; the scan then visits 1 to 16 workers, one per
//   cycle through the shared compare unit, until one qualifies or all are seen.
//   Flow: one transaction is in flight at a time; in_tready is low from
//   acceptance until the result is taken. A stalled receiver holds the result
//   steady on out_tdata/out_tuser and keeps the input blocked.
//   Reset (rst_n low, synchronous) clears the pointer, sets worker_count to 1
//   and policy_mode to random. Registers are to be written over cfg_ only while
//   idle; the block itself does not enforce it.
module worker_select_arbiter #(
  parameter int MAX_WORKERS = wsa_pkg::DEF_MAX_WORKERS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] requester_index, [19:4] long_running_mask,
  // [35:20] nonempty_mask, [39:36] random_value
  input  logic [wsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] selected_worker, [7:4] zero
  output logic [wsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] found
  output logic                            out_tuser,
  // Configuration port.
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [wsa_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [wsa_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [wsa_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int IDX_W   = wsa_pkg::IDX_W;
  localparam int COUNT_W = wsa_pkg::COUNT_W;
  localparam int MASK_W  = wsa_pkg::MASK_BITS;
  // Workers that can take part: bounded by the build size and the mask width.
  localparam int LIMIT   = (MAX_WORKERS < MASK_W) ? MAX_WORKERS : MASK_W;
  localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(LIMIT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Configuration registers.
  logic [COUNT_W-1:0] worker_count_r;
  logic               policy_mode_r;

  // Sequencer state and request payload.
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   rr_next_r, rr_next_nxt;
  logic [IDX_W-1:0]   cand_r, cand_nxt;
  logic [COUNT_W-1:0] visited_r, visited_nxt;
  logic [IDX_W-1:0]   requester_r, requester_nxt;
  logic [MASK_W-1:0]  longrun_r, longrun_nxt;
  logic [MASK_W-1:0]  nonempty_r, nonempty_nxt;
  logic [IDX_W-1:0]   sel_r, sel_nxt;
  logic               found_r, found_nxt;

  logic [COUNT_W-1:0] eff_count;
  logic               cand_ok;
  logic               cand_last;
  logic               cfg_wr;

  // Effective worker count: zero counts as one, large values are limited.
  always_comb begin
    if (worker_count_r == '0) begin
      eff_count = COUNT_W'(1);
    end else if (worker_count_r > LIMIT_C) begin
      eff_count = LIMIT_C;
    end else begin
      eff_count = worker_count_r;
    end
  end

  // Shared compare unit: does the current candidate qualify?
  always_comb begin
    if (policy_mode_r == wsa_pkg::MODE_ROUND_ROBIN) begin
      cand_ok = !longrun_r[cand_r];
    end else begin
      cand_ok = (cand_r != requester_r) && !longrun_r[cand_r] && nonempty_r[cand_r];
    end
    cand_last = ({1'b0, cand_r} + COUNT_W'(1)) == eff_count;
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    rr_next_nxt   = rr_next_r;
    cand_nxt      = cand_r;
    visited_nxt   = visited_r;
    requester_nxt = requester_r;
    longrun_nxt   = longrun_r;
    nonempty_nxt  = nonempty_r;
    sel_nxt       = sel_r;
    found_nxt     = found_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          requester_nxt = in_tdata[3:0];
          longrun_nxt   = in_tdata[19:4];
          nonempty_nxt  = in_tdata[35:20];
          cand_nxt      = (policy_mode_r == wsa_pkg::MODE_ROUND_ROBIN) ?
                          rr_next_r : in_tdata[39:36];
          visited_nxt   = '0;
          state_nxt     = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // Start index modulo the count, one subtraction per cycle.
        if ({1'b0, cand_r} >= eff_count) begin
          cand_nxt = cand_r - eff_count[IDX_W-1:0];
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cand_ok) begin
          sel_nxt   = cand_r;
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
          if (policy_mode_r == wsa_pkg::MODE_ROUND_ROBIN) begin
            rr_next_nxt = cand_last ? '0 : cand_r + IDX_W'(1);
          end
        end else if (visited_r + COUNT_W'(1) == eff_count) begin
          sel_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          visited_nxt = visited_r + COUNT_W'(1);
          cand_nxt    = cand_last ? '0 : cand_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rr_next_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rr_next_r <= rr_next_nxt;
    end
    cand_r      <= cand_nxt;
    visited_r   <= visited_nxt;
    requester_r <= requester_nxt;
    longrun_r   <= longrun_nxt;
    nonempty_r  <= nonempty_nxt;
    sel_r       <= sel_nxt;
    found_r     <= found_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_DONE);
  assign out_tdata  = {{(wsa_pkg::OUT_TDATA_W-IDX_W){1'b0}}, sel_r};
  assign out_tuser  = found_r;

  // Configuration writes complete in the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= COUNT_W'(1);
      policy_mode_r  <= wsa_pkg::MODE_RANDOM;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        wsa_pkg::REG_WORKER_COUNT: worker_count_r <= cfg_pwdata[COUNT_W-1:0];
        wsa_pkg::REG_POLICY_MODE:  policy_mode_r  <= cfg_pwdata[0];
        default: begin
          worker_count_r <= worker_count_r;
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_paddr[2])
      wsa_pkg::REG_WORKER_COUNT:
        cfg_prdata = {{(wsa_pkg::CFG_DATA_W-COUNT_W){1'b0}}, worker_count_r};
      wsa_pkg::REG_POLICY_MODE:
        cfg_prdata = {{(wsa_pkg::CFG_DATA_W-1){1'b0}}, policy_mode_r};
      default:
        cfg_prdata = '0;
    endcase
  end

endmodule

// ===== design/wsa_checker.sv =====
// Port-level checker for the worker select arbiter, bound to its top level.
// Depends on wsa_pkg for port widths.
module wsa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // Only one transaction is in flight: no request is taken while a result waits.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request accepted while a result is pending");

  // A result never shows in the cycle right after a request is accepted.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result appeared without a scan");

  // A not-found result reports worker zero.
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("not-found result carries a nonzero worker");

  // A stalled result holds steady.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind worker_select_arbiter wsa_checker u_wsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/worker_select_arbiter_check.sv =====
`timescale 1ns / 1ps
// Result checker for the worker select arbiter testbench: watches the request,
// result and configuration channels, predicts each grant and compares it.
// Depends on wsa_pkg.
module worker_select_arbiter_check #(
  parameter int MAX_WORKERS = wsa_pkg::DEF_MAX_WORKERS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [3:0] requester_index, [19:4] long_running_mask,
  // [35:20] nonempty_mask, [39:36] random_value
  input  logic [wsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] selected_worker, [7:4] zero
  input  logic [wsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] found
  input  logic                            out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [wsa_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [wsa_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              mismatch_count,
  output int                              grants_pending
);

  localparam int IDX_W   = wsa_pkg::IDX_W;
  localparam int COUNT_W = wsa_pkg::COUNT_W;

  typedef struct packed {
    logic [wsa_pkg::IDX_W-1:0] worker;
    logic                      found;
    logic [wsa_pkg::IDX_W-1:0] next_ptr;
  } grant_t;

  // Mirror of the block's registers and round-robin pointer.
  logic [wsa_pkg::COUNT_W-1:0] worker_count_q;
  logic                        policy_mode_q;
  logic [wsa_pkg::IDX_W-1:0]   rr_ptr_q;

  grant_t grant_q[$];
  grant_t grant_now;

  // Computes the grant for one request under the given settings.
  function automatic grant_t predict_grant(
    input logic [wsa_pkg::COUNT_W-1:0]   count,
    input logic                          mode,
    input logic [wsa_pkg::IDX_W-1:0]     ptr,
    input logic [wsa_pkg::IDX_W-1:0]     requester,
    input logic [wsa_pkg::MASK_BITS-1:0] long_run,
    input logic [wsa_pkg::MASK_BITS-1:0] nonempty,
    input logic [wsa_pkg::IDX_W-1:0]     rnd
  );
    grant_t g;
    int     n;
    int     lim;
    int     first;
    int     w;
    n = int'(count);
    lim = (MAX_WORKERS < wsa_pkg::MASK_BITS) ? MAX_WORKERS : wsa_pkg::MASK_BITS;
    if (n == 0) n = 1;
    if (n > lim) n = lim;
    g.worker = '0;
    g.found = 1'b0;
    g.next_ptr = ptr;
    if (mode == wsa_pkg::MODE_ROUND_ROBIN) begin
      // A stale pointer from a larger count wraps into range first.
      first = int'(ptr) % n;
      for (int i = 0; i < n && !g.found; i++) begin
        w = (first + i) % n;
        if (!long_run[w]) begin
          g.worker = w[wsa_pkg::IDX_W-1:0];
          g.found = 1'b1;
        end
      end
      if (g.found) g.next_ptr = IDX_W'((int'(g.worker) + 1) % n);
    end else begin
      first = int'(rnd) % n;
      for (int i = 0; i < n && !g.found; i++) begin
        w = (first + i) % n;
        if (w != int'(requester) && !long_run[w] && nonempty[w]) begin
          g.worker = w[wsa_pkg::IDX_W-1:0];
          g.found = 1'b1;
        end
      end
    end
    return g;
  endfunction

  // Counts a mismatch and reports the first few.
  task automatic note_mismatch(input string what, input int want, input int got);
    if (mismatch_count < 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Mirror register writes, predict on each request and compare each result.
  always @(posedge clk) begin
    if (!rst_n) begin
      worker_count_q = COUNT_W'(1);
      policy_mode_q = wsa_pkg::MODE_RANDOM;
      rr_ptr_q = '0;
      grant_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == wsa_pkg::REG_WORKER_COUNT)
          worker_count_q = cfg_pwdata[wsa_pkg::COUNT_W-1:0];
        else
          policy_mode_q = cfg_pwdata[0];
      end

      if (out_tvalid && out_tready) begin
        if (grant_q.size() == 0) begin
          note_mismatch("unexpected result, worker", -1, int'(out_tdata[3:0]));
        end else begin
          grant_now = grant_q.pop_front();
          if (out_tdata[3:0] !== grant_now.worker)
            note_mismatch("selected_worker", int'(grant_now.worker),
                          int'(out_tdata[3:0]));
          if (out_tdata[7:4] !== 4'd0)
            note_mismatch("tdata padding", 0, int'(out_tdata[7:4]));
          if (out_tuser !== grant_now.found)
            note_mismatch("found", int'(grant_now.found), int'(out_tuser));
        end
      end

      if (in_tvalid && in_tready) begin
        grant_now = predict_grant(worker_count_q, policy_mode_q, rr_ptr_q,
                                  in_tdata[3:0], in_tdata[19:4], in_tdata[35:20],
                                  in_tdata[39:36]);
        rr_ptr_q = grant_now.next_ptr;
        grant_q.push_back(grant_now);
      end
    end
    grants_pending = grant_q.size();
  end

endmodule

// ===== test/worker_select_arbiter_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the worker select arbiter: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on wsa_pkg, worker_select_arbiter and worker_select_arbiter_check.
module worker_select_arbiter_tb;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_ITEMS    = 75;
  localparam int SETTLE_CYCLES  = 40;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [wsa_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [wsa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [wsa_pkg::CFG_ADDR_W-1:0]  cfg_paddr;
  logic [wsa_pkg::CFG_DATA_W-1:0]  cfg_pwdata;
  logic [wsa_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                            cfg_pready;

  int fail_count;
  int grants_pending;
  bit idle_en;
  bit long_hold_req;

  worker_select_arbiter uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  worker_select_arbiter_check u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (fail_count),
    .grants_pending (grants_pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog against a hung block.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[worker_select_arbiter] ERROR");
    $finish;
  end

  // Result back-pressure: short random stalls, plus one long hold on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // One register write: setup phase, then access phase.
  task automatic cfg_write(input logic idx, input logic [wsa_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = '0;
    cfg_paddr[2] = idx;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // Stops offering and waits until every predicted grant has come back.
  task automatic drain_grants();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (grants_pending != 0) @(negedge clk);
  endtask

  task automatic set_config(input int count, input logic mode);
    drain_grants();
    cfg_write(wsa_pkg::REG_WORKER_COUNT, count);
    cfg_write(wsa_pkg::REG_POLICY_MODE, {{(wsa_pkg::CFG_DATA_W-1){1'b0}}, mode});
  endtask

  // Offers one request and holds it until the block accepts it.
  task automatic send_request(input logic [3:0] requester, input logic [15:0] long_run,
                              input logic [15:0] nonempty, input logic [3:0] rnd);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {rnd, nonempty, long_run, requester};
    do @(posedge clk); while (!in_tready);
  endtask

  // Random request; masks are shaped so that grants and misses both occur.
  task automatic send_random_request();
    logic [15:0] long_run;
    logic [15:0] nonempty;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    case ($urandom_range(0, 7))
      0: long_run = 16'h0000;
      1: long_run = 16'hFFFF;
      2: long_run = ~(16'h0001 << $urandom_range(0, 15));
      3, 4: long_run = 16'($urandom & $urandom & $urandom);
      default: long_run = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: nonempty = 16'h0000;
      1: nonempty = 16'hFFFF;
      2: nonempty = 16'h0001 << $urandom_range(0, 15);
      3, 4: nonempty = 16'($urandom | $urandom);
      default: nonempty = 16'($urandom);
    endcase
    send_request(4'($urandom_range(0, 15)), long_run, nonempty,
                 4'($urandom_range(0, 15)));
  endtask

  initial begin
    int count;
    logic mode;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idle_en = 1'b1;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: one worker, random mode; the requester is the only one.
    send_request(4'd0, 16'h0000, 16'hFFFF, 4'd0);
    send_request(4'd15, 16'h0000, 16'hFFFF, 4'd15);
    // A count of zero behaves as one.
    set_config(0, wsa_pkg::MODE_RANDOM);
    send_request(4'd15, 16'hFFFE, 16'h0001, 4'd7);

    // Round robin over all workers, with a miss and a wrap of the pointer.
    set_config(16, wsa_pkg::MODE_ROUND_ROBIN);
    send_request(4'd0, 16'h0000, 16'h0000, 4'd0);
    send_request(4'd15, 16'hFFFF, 16'hFFFF, 4'd15);
    send_request(4'd3, 16'h0003, 16'h0000, 4'd9);
    send_request(4'd0, 16'h7FFF, 16'h0000, 4'd0);
    send_request(4'd0, 16'h03FF, 16'h0000, 4'd0);
    // Pointer now past the new count, so it wraps before the scan.
    set_config(5, wsa_pkg::MODE_ROUND_ROBIN);
    send_request(4'd0, 16'h0000, 16'h0000, 4'd0);
    // Counts beyond the mask width are clamped.
    set_config(31, wsa_pkg::MODE_ROUND_ROBIN);
    send_request(4'd7, 16'hBFFF, 16'h1234, 4'd3);

    // Random start: requester skipped, empty queues and long tasks skipped.
    set_config(16, wsa_pkg::MODE_RANDOM);
    send_request(4'd15, 16'h0000, 16'hFFFF, 4'd15);
    send_request(4'd0, 16'h0000, 16'h0000, 4'd0);
    send_request(4'd4, 16'hFFFF, 16'hFFFF, 4'd4);
    send_request(4'd4, 16'h0000, 16'h0010, 4'd4);
    // Start above the count, and a requester outside the active workers.
    set_config(5, wsa_pkg::MODE_RANDOM);
    send_request(4'd9, 16'h0000, 16'hFFFF, 4'd13);
    send_request(4'd3, 16'h0000, 16'h0008, 4'd15);
    set_config(31, wsa_pkg::MODE_RANDOM);
    send_request(4'd15, 16'h7FFF, 16'hFFFF, 4'd15);
    send_request(4'd0, 16'h0000, 16'h8000, 4'd1);

    // Random requests over a series of settings, extremes first.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin count = 1;  mode = wsa_pkg::MODE_ROUND_ROBIN; end
        1: begin count = 16; mode = wsa_pkg::MODE_RANDOM; end
        2: begin count = 0;  mode = wsa_pkg::MODE_ROUND_ROBIN; end
        3: begin count = 31; mode = wsa_pkg::MODE_RANDOM; end
        4: begin count = 2;  mode = wsa_pkg::MODE_ROUND_ROBIN; end
        5: begin count = 16; mode = wsa_pkg::MODE_ROUND_ROBIN; end
        6: begin count = 2;  mode = wsa_pkg::MODE_RANDOM; end
        default: begin
          count = int'($urandom_range(0, 31));
          mode = 1'($urandom_range(0, 1));
        end
      endcase
      if (p >= RANDOM_PHASES - 2) idle_en = 1'b0;
      set_config(count, mode);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Long receiver hold while requests keep coming.
        if (p == 3 && i == 10) long_hold_req = 1'b1;
        // Sender pause until every grant is back.
        if (p == 5 && i == 30) begin
          drain_grants();
          repeat ($urandom_range(1, 20)) @(negedge clk);
        end
        send_random_request();
      end
    end

    drain_grants();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && grants_pending == 0) begin
      $display("[worker_select_arbiter] OK");
    end else begin
      $display("[worker_select_arbiter] ERROR");
    end
    $finish;
  end

endmodule

// ===== worker_select_arbiter.f =====
design/wsa_pkg.sv
design/worker_select_arbiter.sv
design/wsa_checker.sv
test/worker_select_arbiter_check.sv
test/worker_select_arbiter_tb.sv
